>>> rtl/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and codes of the stable sorted priority queue
// Entry, command and result words used by the cell row, the output buffer
// and the top level.
// ----------------------------------------------------------------------------
package ssq_pkg;

   localparam int KEY_W     = 16;
   localparam int HANDLE_W  = 16;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   // action codes on the request side
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   // status codes on the response side
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [HANDLE_W-1:0]     handle;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    out_valid;
      logic signed [KEY_W-1:0] out_key;
      logic [HANDLE_W-1:0]     out_handle;
      logic [OCC_W-1:0]        occupancy;
   } result_type;

endpackage

>>> rtl/ssq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cell: one slot of the sorted row
// Holds one entry; on insert keeps, takes the new entry or takes its upper
// neighbor's entry; on remove takes its lower neighbor's entry.
// ----------------------------------------------------------------------------
module ssq_cell (
   input  logic               clock,
   input  ssq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  logic               prev_stays,
   input  ssq_pkg::entry_type prev_entry,
   input  ssq_pkg::entry_type next_entry,
   output logic               stays,
   output ssq_pkg::entry_type entry
);

   ssq_pkg::entry_type entry_ff;
   ssq_pkg::entry_type entry_in;

   // equal keys stay ahead of the new entry: keeps arrival order
   assign stays = occupied && ($signed(entry_ff.key) >= $signed(cmd.entry.key));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (stays) begin
            entry_in = entry_ff;
         end else if (prev_stays) begin
            entry_in = cmd.entry;
         end else begin
            entry_in = prev_entry;
         end
      end else if (cmd.remove) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/ssq_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_skid: two-deep response buffer
// Output register plus skid register, so a new request can be taken while a
// finished response still waits on a stalled receiver.
// ----------------------------------------------------------------------------
module ssq_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ssq_pkg::result_type push_word,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output ssq_pkg::result_type out_word
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   ssq_pkg::result_type main_word_ff, main_word_in;
   ssq_pkg::result_type skid_word_ff, skid_word_in;
   logic                pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            // drain skid into the output register
            main_word_in  = skid_word_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_word_in  = push_word;
            main_valid_in = push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_word_in  = push_word;
            skid_valid_in = 1'b1;
         end else begin
            main_word_in  = push_word;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

>>> rtl/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue: max-first priority queue as a row of cells
// Keeps up to CAPACITY entries sorted by signed key, equal keys in arrival
// order.
// ----------------------------------------------------------------------------
// For each request word (insert or remove) the command is broadcast to a row
// of CAPACITY cells; every cell compares its own key with the new key and
// decides in the same cycle whether to keep its entry, take the new one or
// take a neighbor's, so one word can be accepted every cycle while req_stall
// is low, whatever the fill level. Every request yields exactly one response
// word, registered in a two-deep buffer before it appears on the rsp_ side;
// req_stall rises only when both buffer slots hold words that the receiver
// has not yet taken. Inserting into a full queue drops the entry and reports
// STATUS_FULL; removing from an empty queue reports STATUS_EMPTY. Slots hold
// no reset value; reset clears only the entry count and the valid flags of
// the response buffer.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic signed [15:0] req_priority_key,
   input  logic [15:0] req_entry_handle,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_valid,
   output logic signed [15:0] rsp_out_key,
   output logic [15:0] rsp_out_handle,
   output logic [4:0]  rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // entry count: the only piece of queue state that reset clears
   logic [CNT_W-1:0] count_ff, count_in;

   logic                push;
   logic                is_full, is_empty;
   ssq_pkg::cmd_type    cmd;
   ssq_pkg::result_type result;
   logic [CNT_W+4:0]    count_wide;

   ssq_pkg::entry_type  cell_entry [CAPACITY];
   logic                cell_stays [CAPACITY];

   ssq_pkg::result_type rsp_word;

   // accept a word whenever the response buffer has room
   assign push     = req_valid && !req_stall;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // build the command broadcast to the row; block inserts when full and
   // removes when empty so the row holds still
   always_comb begin
      cmd.entry.key    = req_priority_key;
      cmd.entry.handle = req_entry_handle;
      cmd.insert = push && (req_action == ssq_pkg::ACTION_INSERT) && !is_full;
      cmd.remove = push && (req_action == ssq_pkg::ACTION_REMOVE) && !is_empty;
   end

   // row of cells: cell 0 is the head; data moves down on insert, up on remove
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ssq_pkg::entry_type prev_entry;
      ssq_pkg::entry_type next_entry;
      logic               prev_stays;
      logic               occupied;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_entry = cmd.entry;
         assign prev_stays = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_stays = cell_stays[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // last slot falls out of range on remove; its content no longer matters
         assign next_entry = cell_entry[i];
      end else begin : g_link
         assign next_entry = cell_entry[i+1];
      end

      ssq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occupied),
         .prev_stays (prev_stays),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .stays      (cell_stays[i]),
         .entry      (cell_entry[i])
      );
   end

   // advance the count with the row
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response word: head entry on a good remove, zeros otherwise;
   // occupancy shows the low five bits of the count after the operation
   assign count_wide = (CNT_W + 5)'(count_in);

   always_comb begin
      result.status     = ssq_pkg::STATUS_OK;
      result.out_valid  = 1'b0;
      result.out_key    = '0;
      result.out_handle = '0;
      result.occupancy  = count_wide[4:0];
      if (req_action == ssq_pkg::ACTION_INSERT) begin
         if (is_full) begin
            result.status = ssq_pkg::STATUS_FULL;
         end
      end else begin
         if (is_empty) begin
            result.status = ssq_pkg::STATUS_EMPTY;
         end else begin
            result.out_valid  = 1'b1;
            result.out_key    = cell_entry[0].key;
            result.out_handle = cell_entry[0].handle;
         end
      end
   end

   // hold finished words until the receiver takes them
   ssq_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (result),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

   assign rsp_status     = rsp_word.status;
   assign rsp_out_valid  = rsp_word.out_valid;
   assign rsp_out_key    = rsp_word.out_key;
   assign rsp_out_handle = rsp_word.out_handle;
   assign rsp_occupancy  = rsp_word.occupancy;

   // the skid slot fills only behind a waiting output word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response word pending");

   // the count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // a delivered entry always carries the ok status
   a_entry_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (rsp_status == ssq_pkg::STATUS_OK))
      else $error("delivered entry with error status");

   // a good remove drops the count by one
   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not decrement the count");

   // a drop on full leaves the count at capacity
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (push && (req_action == ssq_pkg::ACTION_INSERT) && is_full)
         |=> (count_ff == CNT_W'(CAPACITY)))
      else $error("dropped insert changed the count");

endmodule
